@@ hw/rtl/sbsc_pkg.sv @@
// Package with shared types, constants and tables of the six-step controller.
`default_nettype none
package sbsc_pkg;
    localparam int DUTY_MAX = 255;
    localparam int STEP_COUNT_BITS = 16;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_SAMPLE = 2'd1;
    localparam logic [1:0] MODE_TARGET = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [2:0] REG_DEBOUNCE = 3'd0;
    localparam logic [2:0] REG_MIN_TGT  = 3'd1;
    localparam logic [2:0] REG_START    = 3'd2;
    localparam logic [2:0] REG_OVS      = 3'd3;
    localparam logic [2:0] REG_KP       = 3'd4;
    localparam logic [2:0] REG_KD       = 3'd5;
    localparam logic [2:0] REG_WINDOW   = 3'd6;
    localparam logic [2:0] REG_SCALE    = 3'd7;

    typedef struct packed {
        logic [7:0] debounce_count;
        logic [9:0] launch_target;
        logic [7:0] start_duty;
        logic [9:0] overspeed_limit;
        logic [7:0] proportional_gain;
        logic [7:0] derivative_gain;
        logic [9:0] window_ms;
        logic [7:0] rps_scale;
    } cfg_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       comp_a;
        logic       comp_b;
        logic       comp_c;
        logic [9:0] target_rps;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  high_gates;
        logic [2:0]  low_pwm_select;
        logic [7:0]  pwm_duty;
        logic        running;
        logic [21:0] speed_q8;
        logic        commutated;
        logic        overspeed_stop;
    } out_word_t;

    function automatic logic [2:0] pat_high(input logic [2:0] p);
        case (p) inside
            3'd0, 3'd1: pat_high = 3'b001;
            3'd2, 3'd3: pat_high = 3'b010;
            3'd4, 3'd5: pat_high = 3'b100;
            default:    pat_high = 3'b001;
        endcase
    endfunction

    function automatic logic [2:0] pat_low(input logic [2:0] p);
        case (p) inside
            3'd0:       pat_low = 3'b010;
            3'd1, 3'd2: pat_low = 3'b100;
            3'd3, 3'd4: pat_low = 3'b001;
            3'd5:       pat_low = 3'b010;
            default:    pat_low = 3'b010;
        endcase
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/sbsc_stream_if.sv @@
// Valid/ready stream interfaces for input and result words.
`default_nettype none
interface sbsc_in_if import sbsc_pkg::*; ();
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface sbsc_out_if import sbsc_pkg::*; ();
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/sensorless_bldc_six_step_controller_unit.sv @@
// Sensorless six-step controller: sequencer, state, shared multiplier and result register.
// Each accepted word passes EXEC and OUT; a tick that closes a window also passes SPEED,
// and while running also PTERM, DTERM and APPLY (speed, P, D, update) before OUT.
// One word at a time, accepted the cycle after the result is taken; SPEED, PTERM and DTERM
// share the one multiplier.
// Reset (rst_n, asynchronous) stops the motor and loads the register defaults.
`default_nettype none
module sensorless_bldc_six_step_controller_unit import sbsc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    sbsc_in_if.sink          in_ch,
    sbsc_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_SPEED = 7'b0000100,
        S_PTERM = 7'b0001000,
        S_DTERM = 7'b0010000,
        S_APPLY = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    cfg_t cfg;
    sbsc_regs u_regs (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .cfg
    );

    state_t state_reg, state_next;
    in_word_t in_reg;
    logic [2:0] step_reg, pat_reg;
    logic [7:0] match_reg;
    logic [STEP_COUNT_BITS-1:0] steps_reg;
    logic [9:0] ms_reg, tgt_reg;
    logic [21:0] speed_reg;
    logic signed [31:0] perr_reg, accum_reg;
    logic spin_reg, comm_reg, ovs_reg;
    logic signed [47:0] acc_reg;
    logic signed [32:0] err_reg;
    logic signed [23:0] delta_reg;
    logic out_valid_reg;
    out_word_t out_reg;

    logic signed [24:0] op_a;
    logic signed [10:0] op_b;
    logic signed [47:0] addend, alu_res;
    sbsc_alu u_alu (.op_a, .op_b, .addend, .result(alu_res));

    logic signed [32:0] err_c;
    logic signed [47:0] rnd_c, sum_c;
    logic [7:0] duty_c;
    logic [21:0] sp_c;
    logic [2:0] step_c, watch_sel;
    logic level_c, match_hit, window_hit, accept;
    logic [7:0] match_inc, need_c;
    logic [10:0] ms_inc;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        addend = '0;
        unique case (state_reg)
            S_SPEED:
            begin
                op_a = 25'($signed({1'b0, steps_reg}));
                op_b = 11'($signed({1'b0, cfg.rps_scale}));
            end
            S_PTERM:
            begin
                op_a = 25'(err_c);
                op_b = 11'($signed({1'b0, cfg.proportional_gain}));
            end
            S_DTERM:
            begin
                op_a = 25'(err_reg - 33'(perr_reg));
                op_b = 11'($signed({1'b0, cfg.derivative_gain}));
                addend = acc_reg;
            end
            default: ;
        endcase
    end

    assign sp_c = (alu_res > 48'sh3FFFFF) ? 22'h3FFFFF : 22'(alu_res);
    assign err_c = $signed({15'd0, tgt_reg, 8'd0}) - $signed({11'd0, speed_reg});
    // Round to nearest with halves up: an arithmetic shift of sum+128 floors.
    assign rnd_c = (acc_reg + 48'sd128) >>> 8;
    always_comb
    begin
        sum_c = 48'(accum_reg) + rnd_c;
        if (sum_c > 48'sh7FFFFFFF) sum_c = 48'sh7FFFFFFF;
        else if (sum_c < -48'sh80000000) sum_c = -48'sh80000000;
    end

    always_comb
    begin
        if (accum_reg < 0) duty_c = 8'd0;
        else if (accum_reg >= 32'(DUTY_MAX * 256)) duty_c = 8'(DUTY_MAX);
        else duty_c = 8'((accum_reg + 32'sd128) >>> 8);
    end

    always_comb
    begin
        step_c = (step_reg > 3'd5) ? 3'd0 : step_reg;
        case (step_c) inside
            3'd0, 3'd3: watch_sel = 3'b001;
            3'd1, 3'd4: watch_sel = 3'b100;
            default:    watch_sel = 3'b010;
        endcase
        level_c = (watch_sel[0] & in_reg.comp_a) | (watch_sel[1] & in_reg.comp_b)
                | (watch_sel[2] & in_reg.comp_c);
        // A debounce count of zero behaves as one.
        need_c = (cfg.debounce_count == 8'd0) ? 8'd1 : cfg.debounce_count;
        match_inc = match_reg + 8'd1;
        match_hit = (match_inc >= need_c);
        ms_inc = {1'b0, ms_reg} + 11'd1;
        window_hit = (ms_inc >= {1'b0, cfg.window_ms});
    end

    assign in_ch.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_EXEC;
            S_EXEC:  state_next = (in_reg.mode == MODE_TICK && window_hit) ? S_SPEED : S_OUT;
            S_SPEED: state_next = spin_reg ? S_PTERM : S_OUT;
            S_PTERM: state_next = S_DTERM;
            S_DTERM: state_next = S_APPLY;
            S_APPLY: state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            in_reg <= '0;
            step_reg <= '0; pat_reg <= '0; match_reg <= '0; steps_reg <= '0;
            ms_reg <= '0; speed_reg <= '0; perr_reg <= '0; accum_reg <= '0;
            spin_reg <= 1'b0; tgt_reg <= '0; comm_reg <= 1'b0; ovs_reg <= 1'b0;
            acc_reg <= '0; err_reg <= '0; delta_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT) out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ch.ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        in_reg <= in_ch.data;
                        comm_reg <= 1'b0;
                        ovs_reg <= 1'b0;
                    end
                end
                S_EXEC:
                begin
                    case (in_reg.mode)
                        MODE_TICK: ms_reg <= window_hit ? 10'd0 : ms_inc[9:0];
                        MODE_SAMPLE:
                        begin
                            if (spin_reg)
                            begin
                                if (level_c == step_c[0])
                                begin
                                    if (match_hit)
                                    begin
                                        match_reg <= '0;
                                        pat_reg <= step_c;
                                        step_reg <= (step_c == 3'd5) ? 3'd0 : step_c + 3'd1;
                                        steps_reg <= steps_reg + STEP_COUNT_BITS'(1);
                                        comm_reg <= 1'b1;
                                    end
                                    else
                                        match_reg <= match_inc;
                                end
                                else
                                    match_reg <= '0;
                            end
                        end
                        MODE_TARGET:
                        begin
                            if (in_reg.target_rps == 10'd0)
                            begin
                                spin_reg <= 1'b0;
                                tgt_reg <= '0;
                            end
                            else if (!spin_reg)
                            begin
                                // Start-up: duty starts from start_duty and the target from launch_target.
                                spin_reg <= 1'b1;
                                accum_reg <= $signed({16'd0, cfg.start_duty, 8'd0});
                                step_reg <= 3'd5;
                                pat_reg <= 3'd4;
                                ms_reg <= '0;
                                steps_reg <= '0;
                                match_reg <= '0;
                                tgt_reg <= cfg.launch_target;
                            end
                            else
                                tgt_reg <= in_reg.target_rps;
                        end
                        default: ;
                    endcase
                end
                S_SPEED:
                begin
                    delta_reg <= $signed({2'b0, sp_c}) - $signed({2'b0, speed_reg});
                    speed_reg <= sp_c;
                    steps_reg <= '0;
                end
                S_PTERM:
                begin
                    acc_reg <= alu_res;
                    err_reg <= err_c;
                end
                S_DTERM:
                begin
                    acc_reg <= alu_res;
                    perr_reg <= 32'(err_reg);
                end
                S_APPLY:
                begin
                    accum_reg <= 32'(sum_c);
                    if (delta_reg > $signed({6'd0, cfg.overspeed_limit, 8'd0}))
                    begin
                        spin_reg <= 1'b0;
                        ovs_reg <= 1'b1;
                    end
                end
                S_OUT:
                begin
                    out_reg.high_gates <= spin_reg ? pat_high(pat_reg) : 3'd0;
                    out_reg.low_pwm_select <= spin_reg ? pat_low(pat_reg) : 3'd0;
                    out_reg.pwm_duty <= spin_reg ? duty_c : 8'd0;
                    out_reg.running <= spin_reg;
                    out_reg.speed_q8 <= speed_reg;
                    out_reg.commutated <= comm_reg;
                    out_reg.overspeed_stop <= ovs_reg;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/sbsc_regs.sv @@
// APB register file holding the controller configuration.
`default_nettype none
module sbsc_regs import sbsc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);
    cfg_t cfg_reg;
    logic [2:0] idx;
    assign idx = paddr[4:2];
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_count    <= 8'd10;
            cfg_reg.launch_target     <= 10'd60;
            cfg_reg.start_duty        <= 8'd100;
            cfg_reg.overspeed_limit   <= 10'd100;
            cfg_reg.proportional_gain <= 8'd51;
            cfg_reg.derivative_gain   <= 8'd128;
            cfg_reg.window_ms         <= 10'd100;
            cfg_reg.rps_scale         <= 8'd61;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_DEBOUNCE: cfg_reg.debounce_count    <= pwdata[7:0];
                REG_MIN_TGT:  cfg_reg.launch_target     <= pwdata[9:0];
                REG_START:    cfg_reg.start_duty        <= pwdata[7:0];
                REG_OVS:      cfg_reg.overspeed_limit   <= pwdata[9:0];
                REG_KP:       cfg_reg.proportional_gain <= pwdata[7:0];
                REG_KD:       cfg_reg.derivative_gain   <= pwdata[7:0];
                REG_WINDOW:   cfg_reg.window_ms         <= pwdata[9:0];
                REG_SCALE:    cfg_reg.rps_scale         <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_DEBOUNCE: prdata[7:0] = cfg_reg.debounce_count;
            REG_MIN_TGT:  prdata[9:0] = cfg_reg.launch_target;
            REG_START:    prdata[7:0] = cfg_reg.start_duty;
            REG_OVS:      prdata[9:0] = cfg_reg.overspeed_limit;
            REG_KP:       prdata[7:0] = cfg_reg.proportional_gain;
            REG_KD:       prdata[7:0] = cfg_reg.derivative_gain;
            REG_WINDOW:   prdata[9:0] = cfg_reg.window_ms;
            REG_SCALE:    prdata[7:0] = cfg_reg.rps_scale;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ hw/rtl/sbsc_alu.sv @@
// Shared multiply-accumulate unit: one signed 25x11 product plus an addend.
`default_nettype none
module sbsc_alu import sbsc_pkg::*; (
    input  wire logic signed [24:0] op_a,
    input  wire logic signed [10:0] op_b,
    input  wire logic signed [47:0] addend,
    output logic signed [47:0]      result
);
    logic signed [35:0] prod;
    assign prod = op_a * op_b;
    assign result = addend + 48'(prod);
endmodule
`default_nettype wire

@@ dv/sensorless_bldc_six_step_controller_unit_tb.sv @@
// Self-checking testbench of the sensorless six-step controller with an APB register port.
module sensorless_bldc_six_step_controller_unit_tb;
    import sbsc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sbsc_in_if  in_ch();
    sbsc_out_if out_ch();

    sensorless_bldc_six_step_controller_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    localparam int CYCLE_LIMIT = 400000;

    // Register copy used by the controller model.
    int unsigned debounce_r, min_tgt_r, start_duty_r, ovs_limit_r;
    int unsigned kp_r, kd_r, window_r, scale_r;

    // Controller model state.
    logic [2:0]  step_q, pattern_q;
    logic [7:0]  match_q;
    logic [15:0] steps_q;
    logic [9:0]  ms_q;
    logic [21:0] speed_q;
    longint      prev_err_q, accum_q;
    logic        spin_q;
    logic [9:0]  target_q;

    out_word_t expected_words[$];
    int        error_count;
    int        word_count;
    int        commutation_count;
    int        overspeed_count;
    longint    cycle_count;
    bit        long_hold;
    bit        stim_done;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic void load_defaults();
        debounce_r = 10; min_tgt_r = 60; start_duty_r = 100; ovs_limit_r = 100;
        kp_r = 51; kd_r = 128; window_r = 100; scale_r = 61;
        step_q = 0; pattern_q = 0; match_q = 0; steps_q = 0; ms_q = 0;
        speed_q = 0; prev_err_q = 0; accum_q = 0; spin_q = 0; target_q = 0;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [7:0] duty_of_accum();
        if (accum_q < 0)
            return 8'd0;
        if (accum_q >= longint'(DUTY_MAX) * 256)
            return 8'(DUTY_MAX);
        return 8'((accum_q + 128) >>> 8);
    endfunction

    // Closes a measurement window; returns 1 when the speed rise stops the motor.
    function automatic bit close_window();
        longint sp, delta, err, der, sum, x, inc;
        sp = longint'(steps_q) * scale_r;
        if (sp > 64'h3FFFFF)
            sp = 64'h3FFFFF;
        delta = sp - longint'(speed_q);
        speed_q = 22'(sp);
        steps_q = 0;
        if (!spin_q)
            return 1'b0;
        err = longint'(target_q) * 256 - longint'(speed_q);
        der = err - prev_err_q;
        sum = longint'(kp_r) * err + longint'(kd_r) * der;
        prev_err_q = err;
        // Round to nearest with halves going up, also for negative sums.
        x = sum + 128;
        if (x >= 0)
            inc = x / 256;
        else
            inc = -((-x + 255) / 256);
        accum_q = sat32(accum_q + inc);
        if (delta > longint'(ovs_limit_r) * 256)
        begin
            spin_q = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic out_word_t predict_controller(in_word_t w);
        out_word_t r;
        bit        comm, ovs, lvl;
        int        need;
        logic [2:0] k;
        comm = 0;
        ovs = 0;
        r = '0;
        if (w.mode == MODE_TICK)
        begin
            if (int'(ms_q) + 1 >= int'(window_r))
            begin
                ms_q = 0;
                ovs = close_window();
            end
            else
                ms_q = ms_q + 10'd1;
        end
        else if (w.mode == MODE_SAMPLE)
        begin
            if (spin_q)
            begin
                k = (step_q < 6) ? step_q : 3'd0;
                case (k) inside
                    3'd0, 3'd3: lvl = w.comp_a;
                    3'd1, 3'd4: lvl = w.comp_c;
                    default:    lvl = w.comp_b;
                endcase
                if (lvl == k[0])
                begin
                    need = (debounce_r == 0) ? 1 : debounce_r;
                    match_q = match_q + 8'd1;
                    if (int'(match_q) >= need)
                    begin
                        match_q = 0;
                        pattern_q = k;
                        step_q = (k == 5) ? 3'd0 : k + 3'd1;
                        steps_q = steps_q + 16'd1;
                        comm = 1;
                    end
                end
                else
                    match_q = 0;
            end
        end
        else if (w.mode == MODE_TARGET)
        begin
            if (w.target_rps == 0)
            begin
                spin_q = 0;
                target_q = 0;
            end
            else if (!spin_q)
            begin
                spin_q = 1;
                accum_q = longint'(start_duty_r) * 256;
                step_q = 5;
                pattern_q = 4;
                ms_q = 0;
                steps_q = 0;
                match_q = 0;
                target_q = 10'(min_tgt_r);
            end
            else
                target_q = w.target_rps;
        end
        if (spin_q)
        begin
            case (pattern_q)
                3'd0: begin r.high_gates = 3'b001; r.low_pwm_select = 3'b010; end
                3'd1: begin r.high_gates = 3'b001; r.low_pwm_select = 3'b100; end
                3'd2: begin r.high_gates = 3'b010; r.low_pwm_select = 3'b100; end
                3'd3: begin r.high_gates = 3'b010; r.low_pwm_select = 3'b001; end
                3'd4: begin r.high_gates = 3'b100; r.low_pwm_select = 3'b001; end
                default: begin r.high_gates = 3'b100; r.low_pwm_select = 3'b010; end
            endcase
            r.pwm_duty = duty_of_accum();
            r.running = 1;
        end
        r.speed_q8 = speed_q;
        r.commutated = comm;
        r.overspeed_stop = ovs;
        return r;
    endfunction

    task automatic write_register(logic [2:0] index, int unsigned value);
        @(negedge clk);
        psel = 1; penable = 0; pwrite = 1;
        paddr = {index, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel = 0; penable = 0; pwrite = 0;
        case (index)
            REG_DEBOUNCE: debounce_r = value & 8'hFF;
            REG_MIN_TGT:  min_tgt_r = value & 10'h3FF;
            REG_START:    start_duty_r = value & 8'hFF;
            REG_OVS:      ovs_limit_r = value & 10'h3FF;
            REG_KP:       kp_r = value & 8'hFF;
            REG_KD:       kd_r = value & 8'hFF;
            REG_WINDOW:   window_r = value & 10'h3FF;
            default:      scale_r = value & 8'hFF;
        endcase
    endtask

    // Waits for the block to drain before a register write.
    task automatic wait_idle();
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_word(in_word_t w, bit check_fixed, out_word_t fixed);
        out_word_t e;
        @(negedge clk);
        in_ch.valid = 1;
        in_ch.data = w;
        do
            @(posedge clk);
        while (!in_ch.ready);
        e = predict_controller(w);
        if (check_fixed && e != fixed)
        begin
            $error("directed row: expected %h, model %h", fixed, e);
            error_count++;
        end
        expected_words.push_back(check_fixed ? fixed : e);
        // Gap after a burst ends.
        if ($urandom_range(0, 7) == 0)
        begin
            @(negedge clk);
            in_ch.valid = 0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    function automatic in_word_t make_word(logic [1:0] m, logic [2:0] c, logic [9:0] t);
        in_word_t w;
        w.mode = m;
        {w.comp_c, w.comp_b, w.comp_a} = c;
        w.target_rps = t;
        return w;
    endfunction

    // Sample that shows the level the current step expects.
    function automatic in_word_t matching_sample();
        logic [2:0] c;
        logic [2:0] k;
        c = 3'($urandom);
        k = step_q;
        case (k) inside
            3'd0, 3'd3: c[0] = k[0];
            3'd1, 3'd4: c[2] = k[0];
            default:    c[1] = k[0];
        endcase
        return make_word(MODE_SAMPLE, c, 10'($urandom));
    endfunction

    // Receiver: random stall pattern plus one long hold-off.
    initial
    begin
        out_ch.ready = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ch.ready = 0;
                repeat (60) @(negedge clk);
                long_hold = 0;
            end
            out_ch.ready = ($urandom_range(0, 99) < 70) || (cycle_count % 500 < 100);
        end
    end

    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected");
                error_count++;
            end
            else
            begin
                e = expected_words.pop_front();
                word_count++;
                if (out_ch.data.commutated)
                    commutation_count++;
                if (out_ch.data.overspeed_stop)
                    overspeed_count++;
                if (out_ch.data.high_gates !== e.high_gates)
                begin
                    $error("high_gates exp %0d got %0d", e.high_gates, out_ch.data.high_gates);
                    error_count++;
                end
                if (out_ch.data.low_pwm_select !== e.low_pwm_select)
                begin
                    $error("low_pwm_select exp %0d got %0d", e.low_pwm_select,
                           out_ch.data.low_pwm_select);
                    error_count++;
                end
                if (out_ch.data.pwm_duty !== e.pwm_duty)
                begin
                    $error("pwm_duty exp %0d got %0d", e.pwm_duty, out_ch.data.pwm_duty);
                    error_count++;
                end
                if (out_ch.data.running !== e.running)
                begin
                    $error("running exp %0d got %0d", e.running, out_ch.data.running);
                    error_count++;
                end
                if (out_ch.data.speed_q8 !== e.speed_q8)
                begin
                    $error("speed_q8 exp %0d got %0d", e.speed_q8, out_ch.data.speed_q8);
                    error_count++;
                end
                if (out_ch.data.commutated !== e.commutated)
                begin
                    $error("commutated exp %0d got %0d", e.commutated, out_ch.data.commutated);
                    error_count++;
                end
                if (out_ch.data.overspeed_stop !== e.overspeed_stop)
                begin
                    $error("overspeed_stop exp %0d got %0d", e.overspeed_stop,
                           out_ch.data.overspeed_stop);
                    error_count++;
                end
            end
        end
    end

    typedef struct {
        logic [1:0] mode;
        logic [2:0] comps;
        logic [9:0] target;
        bit         fixed;
        out_word_t  result;
    } dir_row_t;

    // Directed rows; with defaults the first ones are easy to read off.
    dir_row_t dir_rows[20] = '{
        '{MODE_TICK,   3'b000, 10'd0,   1, '0},
        '{MODE_SAMPLE, 3'b111, 10'd0,   1, '0},
        '{MODE_NONE,   3'b111, 10'h3FF, 1, '0},
        '{MODE_TARGET, 3'b000, 10'd0,   1, '0},
        '{MODE_TARGET, 3'b000, 10'd999, 1,
          '{3'b100, 3'b001, 8'd100, 1'b1, 22'd0, 1'b0, 1'b0}},
        '{MODE_TARGET, 3'b000, 10'd999, 0, '0},
        '{MODE_SAMPLE, 3'b000, 10'd0,   0, '0},
        '{MODE_SAMPLE, 3'b111, 10'd0,   0, '0},
        '{MODE_SAMPLE, 3'b010, 10'd0,   0, '0},
        '{MODE_SAMPLE, 3'b010, 10'd0,   0, '0},
        '{MODE_SAMPLE, 3'b101, 10'd0,   0, '0},
        '{MODE_SAMPLE, 3'b001, 10'd0,   0, '0},
        '{MODE_SAMPLE, 3'b001, 10'd0,   0, '0},
        '{MODE_TICK,   3'b000, 10'd0,   0, '0},
        '{MODE_TICK,   3'b111, 10'd0,   0, '0},
        '{MODE_TICK,   3'b000, 10'd0,   0, '0},
        '{MODE_NONE,   3'b000, 10'd1,   0, '0},
        '{MODE_TARGET, 3'b000, 10'd1,   0, '0},
        '{MODE_TARGET, 3'b000, 10'd0,   1, '0},
        '{MODE_TICK,   3'b000, 10'd0,   0, '0}
    };

    initial
    begin
        in_word_t w;
        int       r, phase, n;
        error_count = 0; word_count = 0; commutation_count = 0; overspeed_count = 0;
        long_hold = 0; stim_done = 0;
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_ch.valid = 0;
        in_ch.data = '0;
        load_defaults();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // A few register writes first; the directed rows start from the defaults.
        write_register(REG_DEBOUNCE, 2);
        write_register(REG_WINDOW, 2);
        write_register(REG_DEBOUNCE, 10);
        write_register(REG_WINDOW, 100);
        foreach (dir_rows[i])
        begin
            w = make_word(dir_rows[i].mode, dir_rows[i].comps, dir_rows[i].target);
            send_word(w, dir_rows[i].fixed, dir_rows[i].result);
            if (i == 5)
            begin
                @(negedge clk);
                in_ch.valid = 0;
                wait_idle();
                write_register(REG_DEBOUNCE, 0);
                write_register(REG_WINDOW, 0);
            end
        end
        @(negedge clk);
        in_ch.valid = 0;

        for (phase = 0; phase < 7; phase++)
        begin
            wait_idle();
            case (phase)
                0: begin
                    write_register(REG_DEBOUNCE, 1); write_register(REG_MIN_TGT, 999);
                    write_register(REG_START, 255); write_register(REG_OVS, 0);
                    write_register(REG_KP, 255); write_register(REG_KD, 255);
                    write_register(REG_WINDOW, 1); write_register(REG_SCALE, 255);
                end
                1: begin
                    write_register(REG_DEBOUNCE, 255); write_register(REG_MIN_TGT, 0);
                    write_register(REG_START, 0); write_register(REG_OVS, 1023);
                    write_register(REG_KP, 0); write_register(REG_KD, 0);
                    write_register(REG_WINDOW, 1023); write_register(REG_SCALE, 1);
                end
                default: begin
                    write_register(REG_DEBOUNCE, $urandom_range(1, 4));
                    write_register(REG_MIN_TGT, $urandom_range(0, 999));
                    write_register(REG_START, $urandom_range(0, 255));
                    write_register(REG_OVS, $urandom_range(0, 1023));
                    write_register(REG_KP, $urandom_range(0, 255));
                    write_register(REG_KD, $urandom_range(0, 255));
                    write_register(REG_WINDOW, $urandom_range(1, 12));
                    write_register(REG_SCALE, $urandom_range(1, 255));
                end
            endcase
            n = (phase == 1) ? 100 : 275;
            for (int i = 0; i < n; i++)
            begin
                if (phase == 3 && i == 50)
                    long_hold = 1;
                r = $urandom_range(0, 99);
                if (!spin_q && r < 30)
                    w = make_word(MODE_TARGET, 3'($urandom), 10'($urandom_range(1, 1023)));
                else if (r < 60)
                    w = matching_sample();
                else if (r < 70)
                    w = make_word(MODE_SAMPLE, 3'($urandom), 10'($urandom));
                else if (r < 90)
                    w = make_word(MODE_TICK, 3'($urandom), 10'($urandom));
                else if (r < 97)
                    w = make_word(MODE_TARGET, 3'($urandom), 10'($urandom));
                else
                    w = make_word(MODE_NONE, 3'($urandom), 10'($urandom));
                send_word(w, 0, '0);
            end
            @(negedge clk);
            in_ch.valid = 0;
        end
        stim_done = 1;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Checked %0d result words, %0d commutations, %0d overspeed stops.",
                 word_count, commutation_count, overspeed_count);
        $display("Register settings covered defaults, extremes and random values.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ sensorless_bldc_six_step_controller_unit.f @@
hw/rtl/sbsc_pkg.sv
hw/rtl/sbsc_stream_if.sv
hw/rtl/sbsc_regs.sv
hw/rtl/sbsc_alu.sv
hw/rtl/sensorless_bldc_six_step_controller_unit.sv
dv/sensorless_bldc_six_step_controller_unit_tb.sv
